// ----- design/nbb_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the net bounding box wire cost block.
// No dependencies; every other file in the design depends on this package.
package nbb_pkg;

    // Table sizing and coordinate width
    localparam int MAX_LINES  = 256;
    localparam int COORD_BITS = 16;

    // Field widths of the request and result channels
    localparam int REQ_TYPE_W = 2;
    localparam int PIN_IDX_W  = 8;
    localparam int COORD_IN_W = 16;
    localparam int WEIGHT_W   = 16;
    localparam int SPAN_W     = 16;
    localparam int FRAC_BITS  = 8;
    localparam int PROD_W     = SPAN_W + WEIGHT_W;
    localparam int COST_W     = 25;
    localparam int TOTAL_W    = 32;

    // Derived widths
    localparam int LINE_IDX_W  = $clog2(MAX_LINES);
    localparam int IDX_CMP_W   = (LINE_IDX_W + 1 > PIN_IDX_W) ? LINE_IDX_W + 1 : PIN_IDX_W;
    localparam int COORD_EXT_W = (COORD_BITS > COORD_IN_W) ? COORD_BITS : COORD_IN_W;
    localparam int SPAN_EXT_W  = (COORD_BITS > SPAN_W) ? COORD_BITS : SPAN_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(256);

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_PIN    = 2'd0,
        REQ_LOAD_X = 2'd1,
        REQ_LOAD_Y = 2'd2
    } req_type_t;

    typedef logic [LINE_IDX_W-1:0] line_addr_t;
    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [SPAN_W-1:0]     span_t;

    // Table read addresses for one finished net, plus the pending total clear
    typedef struct packed {
        line_addr_t x_lo;
        line_addr_t x_hi;
        line_addr_t y_lo;
        line_addr_t y_hi;
        logic       clr;
    } lookup_t;

    // Control that travels with a net through the cost pipeline
    typedef struct packed {
        logic valid;
        logic clr;
    } stage_ctl_t;

    // Saturate a pin index to the last table line
    function automatic line_addr_t clamp_line(input logic [PIN_IDX_W-1:0] idx);
        logic [IDX_CMP_W-1:0] ext;
        ext = IDX_CMP_W'(idx);
        if (ext >= IDX_CMP_W'(MAX_LINES))
            return line_addr_t'(MAX_LINES - 1);
        else
            return ext[LINE_IDX_W-1:0];
    endfunction

    // Check a load index against the table depth
    function automatic logic line_in_range(input logic [PIN_IDX_W-1:0] idx);
        return IDX_CMP_W'(idx) < IDX_CMP_W'(MAX_LINES);
    endfunction

    // Narrow a load index to a table address
    function automatic line_addr_t line_addr(input logic [PIN_IDX_W-1:0] idx);
        logic [IDX_CMP_W-1:0] ext;
        ext = IDX_CMP_W'(idx);
        return ext[LINE_IDX_W-1:0];
    endfunction

    // Fit an incoming coordinate to the stored width
    function automatic coord_t to_coord(input logic [COORD_IN_W-1:0] v);
        logic [COORD_EXT_W-1:0] ext;
        ext = COORD_EXT_W'(v);
        return ext[COORD_BITS-1:0];
    endfunction

    // Span between two line coordinates, clamped at zero, cut to field width
    function automatic span_t span_of(input coord_t hi, input coord_t lo);
        coord_t                d;
        logic [SPAN_EXT_W-1:0] ext;
        d   = hi - lo;
        ext = SPAN_EXT_W'(d);
        if (hi < lo)
            return '0;
        else
            return ext[SPAN_W-1:0];
    endfunction

endpackage

// ----- design/nbb_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request stream, result stream, weight write port.
// Depends on nbb_pkg for field widths.

interface nbb_req_if;
    logic                           valid;
    logic                           ready;
    logic [nbb_pkg::REQ_TYPE_W-1:0] req_type;
    logic [nbb_pkg::PIN_IDX_W-1:0]  line_index;
    logic [nbb_pkg::COORD_IN_W-1:0] line_coord;
    logic [nbb_pkg::PIN_IDX_W-1:0]  pin_x_index;
    logic [nbb_pkg::PIN_IDX_W-1:0]  pin_y_index;
    logic                           last_pin;
    logic                           first_net;

    modport source (output valid, req_type, line_index, line_coord, pin_x_index,
                    pin_y_index, last_pin, first_net, input ready);
    modport sink   (input valid, req_type, line_index, line_coord, pin_x_index,
                    pin_y_index, last_pin, first_net, output ready);
endinterface

interface nbb_res_if;
    logic                        valid;
    logic                        ready;
    logic [nbb_pkg::SPAN_W-1:0]  half_width;
    logic [nbb_pkg::SPAN_W-1:0]  half_height;
    logic [nbb_pkg::COST_W-1:0]  net_cost;
    logic [nbb_pkg::TOTAL_W-1:0] total_cost;

    modport source (output valid, half_width, half_height, net_cost, total_cost,
                    input ready);
    modport sink   (input valid, half_width, half_height, net_cost, total_cost,
                    output ready);
endinterface

interface nbb_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [nbb_pkg::WEIGHT_W-1:0] vertical_weight;

    modport source (output valid, vertical_weight, input ready);
    modport sink   (input valid, vertical_weight, output ready);
endinterface

// ----- design/nbb_line_table.sv -----
`timescale 1ns / 1ps
// Grid line coordinate table: one write port, two registered read ports.
// Depends on nbb_pkg for depth and coordinate width.
module nbb_line_table (
    input  logic            clk,
    input  logic            wr_en,
    input  nbb_pkg::line_addr_t wr_addr,
    input  nbb_pkg::coord_t wr_data,
    input  logic            rd_en,
    input  nbb_pkg::line_addr_t rd_addr_hi,
    input  nbb_pkg::line_addr_t rd_addr_lo,
    output nbb_pkg::coord_t rd_data_hi,
    output nbb_pkg::coord_t rd_data_lo
);
    import nbb_pkg::*;

    coord_t mem [MAX_LINES];
    coord_t rd_hi_reg;
    coord_t rd_lo_reg;

    // Write one line coordinate
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read both box edges, hold while the pipeline stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_hi_reg <= mem[rd_addr_hi];
            rd_lo_reg <= mem[rd_addr_lo];
        end
    end

    assign rd_data_hi = rd_hi_reg;
    assign rd_data_lo = rd_lo_reg;

endmodule

// ----- design/nbb_box_track.sv -----
`timescale 1ns / 1ps
// Bounding box tracker: keeps the current net's min/max line indices and a pending
// total clear, and produces the table addresses for the net's box. Depends on nbb_pkg.
module nbb_box_track (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pin_take,
    input  logic [nbb_pkg::PIN_IDX_W-1:0] pin_x,
    input  logic [nbb_pkg::PIN_IDX_W-1:0] pin_y,
    input  logic                          last_pin,
    input  logic                          first_net,
    output nbb_pkg::lookup_t              lookup
);
    import nbb_pkg::*;

    logic [PIN_IDX_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [PIN_IDX_W-1:0] x_min_next, x_max_next, y_min_next, y_max_next;
    logic                 open_reg;
    logic                 clr_pend_reg;

    // Grow the box, or open it on the first pin of a net
    always_comb
    begin
        if (open_reg)
        begin
            x_min_next = (pin_x < x_min_reg) ? pin_x : x_min_reg;
            x_max_next = (pin_x > x_max_reg) ? pin_x : x_max_reg;
            y_min_next = (pin_y < y_min_reg) ? pin_y : y_min_reg;
            y_max_next = (pin_y > y_max_reg) ? pin_y : y_max_reg;
        end
        else
        begin
            x_min_next = pin_x;
            x_max_next = pin_x;
            y_min_next = pin_y;
            y_max_next = pin_y;
        end
    end

    // Table addresses for the box as it stands after this pin
    always_comb
    begin
        lookup.x_lo = clamp_line(x_min_next);
        lookup.x_hi = clamp_line(x_max_next);
        lookup.y_lo = clamp_line(y_min_next);
        lookup.y_hi = clamp_line(y_max_next);
        lookup.clr  = clr_pend_reg | first_net;
    end

    // Advance box state on each accepted pin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg    <= '0;
            x_max_reg    <= '0;
            y_min_reg    <= '0;
            y_max_reg    <= '0;
            open_reg     <= 1'b0;
            clr_pend_reg <= 1'b0;
        end
        else if (pin_take)
        begin
            x_min_reg    <= x_min_next;
            x_max_reg    <= x_max_next;
            y_min_reg    <= y_min_next;
            y_max_reg    <= y_max_next;
            open_reg     <= !last_pin;
            clr_pend_reg <= last_pin ? 1'b0 : (clr_pend_reg | first_net);
        end
    end

endmodule

// ----- design/nbb_cost_pipe.sv -----
`timescale 1ns / 1ps
// Cost pipeline: spans, weighted height product, net cost, saturating total and the
// result register, with per-stage flow control. Depends on nbb_pkg and nbb_res_if.
module nbb_cost_pipe (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nbb_pkg::stage_ctl_t          s1,
    input  nbb_pkg::coord_t              x_hi,
    input  nbb_pkg::coord_t              x_lo,
    input  nbb_pkg::coord_t              y_hi,
    input  nbb_pkg::coord_t              y_lo,
    input  logic [nbb_pkg::WEIGHT_W-1:0] weight,
    output logic                         s1_free,
    nbb_res_if.source                    res
);
    import nbb_pkg::*;

    stage_ctl_t s2_reg, s3_reg, s4_reg;
    logic       out_valid_reg;
    logic       en2, en3, en4, en_out;

    span_t               hx2_reg, hy2_reg;
    span_t               hx3_reg, hy3_reg;
    logic [PROD_W-1:0]   prod3_reg;
    span_t               hx4_reg, hy4_reg;
    logic [COST_W-1:0]   cost4_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;
    logic [TOTAL_W:0]    total_sum;
    logic [COST_W-1:0]   cost_next;
    span_t               hw_out_reg, hh_out_reg;
    logic [COST_W-1:0]   cost_out_reg;

    // Each stage moves when it is empty or the stage after it is moving
    assign en_out  = !out_valid_reg || res.ready;
    assign en4     = !s4_reg.valid || en_out;
    assign en3     = !s3_reg.valid || en4;
    assign en2     = !s2_reg.valid || en3;
    assign s1_free = !s1.valid || en2;

    // Net cost: width plus weighted height with the fraction dropped
    assign cost_next = COST_W'(hx3_reg) + COST_W'(prod3_reg[PROD_W-1:FRAC_BITS]);

    // Running total, cleared by the first net and pinned at full scale
    always_comb
    begin
        total_sum  = (s4_reg.clr ? (TOTAL_W + 1)'(0) : (TOTAL_W + 1)'(total_reg))
                     + (TOTAL_W + 1)'(cost4_reg);
        total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
    end

    // Stage valids, output valid and total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg        <= '0;
            s3_reg        <= '0;
            s4_reg        <= '0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (en2)
                s2_reg <= s1;
            if (en3)
                s3_reg <= s2_reg;
            if (en4)
                s4_reg <= s3_reg;
            if (en_out)
            begin
                out_valid_reg <= s4_reg.valid;
                if (s4_reg.valid)
                    total_reg <= total_next;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            hx2_reg <= span_of(x_hi, x_lo);
            hy2_reg <= span_of(y_hi, y_lo);
        end
        if (en3)
        begin
            hx3_reg   <= hx2_reg;
            hy3_reg   <= hy2_reg;
            prod3_reg <= PROD_W'(hy2_reg) * PROD_W'(weight);
        end
        if (en4)
        begin
            hx4_reg   <= hx3_reg;
            hy4_reg   <= hy3_reg;
            cost4_reg <= cost_next;
        end
        if (en_out)
        begin
            hw_out_reg   <= hx4_reg;
            hh_out_reg   <= hy4_reg;
            cost_out_reg <= cost4_reg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.half_width  = hw_out_reg;
    assign res.half_height = hh_out_reg;
    assign res.net_cost    = cost_out_reg;
    assign res.total_cost  = total_reg;

    // A blocked pipeline entry means every stage is full and the result is held
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_free |-> (s1.valid && s2_reg.valid && s3_reg.valid && s4_reg.valid
                      && out_valid_reg && !res.ready))
        else $error("pipeline stalled with an empty stage");

    // The total always covers the net that was just added
    a_total_covers_cost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (TOTAL_W'(cost_out_reg) <= total_reg))
        else $error("total below net cost");

    // Net cost never falls below the width span
    a_cost_covers_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (COST_W'(hw_out_reg) <= cost_out_reg))
        else $error("net cost below half width");

    // A unity vertical weight makes the cost the plain half perimeter
    a_unity_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && weight == WEIGHT_RESET)
        |-> (cost_out_reg == COST_W'(hw_out_reg) + COST_W'(hh_out_reg)))
        else $error("unity weight cost mismatch");

endmodule

// ----- design/net_bounding_box_wire_cost.sv -----
`timescale 1ns / 1ps
// Net bounding box wire cost. A last pin's result passes the table read, span,
// product, net cost and total/result registers in that order, and a stall can hold it.
// Throughput: one request per cycle while the result side is not stalled, set by the
// box update and the registered table reads; loads and non-last pins produce no result.
// Reset clears the box, net state, running total and sets the weight to 1.0;
// the line tables are not cleared and must be loaded before use.
module net_bounding_box_wire_cost (
    input  logic      clk,
    input  logic      rst_n,
    nbb_req_if.sink   req,
    nbb_res_if.source res,
    nbb_cfg_if.sink   cfg
);
    import nbb_pkg::*;

    logic [WEIGHT_W-1:0] weight_reg;
    stage_ctl_t          s1_reg;
    lookup_t             lookup;
    logic                s1_free;
    logic                req_take;
    logic                pin_take;
    logic                load_ok;
    logic                wr_x, wr_y;
    line_addr_t          wr_addr;
    coord_t              wr_data;
    coord_t              x_hi, x_lo, y_hi, y_lo;

    // Decode the accepted request
    assign req.ready = s1_free;
    assign req_take  = req.valid && req.ready;
    assign pin_take  = req_take && (req.req_type == REQ_PIN);
    assign load_ok   = req_take && line_in_range(req.line_index);
    assign wr_x      = load_ok && (req.req_type == REQ_LOAD_X);
    assign wr_y      = load_ok && (req.req_type == REQ_LOAD_Y);
    assign wr_addr   = line_addr(req.line_index);
    assign wr_data   = to_coord(req.line_coord);

    // Weight register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            weight_reg <= cfg.vertical_weight;
        end
    end

    // Mark a finished net entering the table read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (s1_free)
        begin
            s1_reg.valid <= pin_take && req.last_pin;
            s1_reg.clr   <= lookup.clr;
        end
    end

    nbb_box_track u_box (
        .clk       (clk),
        .rst_n     (rst_n),
        .pin_take  (pin_take),
        .pin_x     (req.pin_x_index),
        .pin_y     (req.pin_y_index),
        .last_pin  (req.last_pin),
        .first_net (req.first_net),
        .lookup    (lookup)
    );

    nbb_line_table u_x_table (
        .clk        (clk),
        .wr_en      (wr_x),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (s1_free),
        .rd_addr_hi (lookup.x_hi),
        .rd_addr_lo (lookup.x_lo),
        .rd_data_hi (x_hi),
        .rd_data_lo (x_lo)
    );

    nbb_line_table u_y_table (
        .clk        (clk),
        .wr_en      (wr_y),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (s1_free),
        .rd_addr_hi (lookup.y_hi),
        .rd_addr_lo (lookup.y_lo),
        .rd_data_hi (y_hi),
        .rd_data_lo (y_lo)
    );

    nbb_cost_pipe u_cost (
        .clk     (clk),
        .rst_n   (rst_n),
        .s1      (s1_reg),
        .x_hi    (x_hi),
        .x_lo    (x_lo),
        .y_hi    (y_hi),
        .y_lo    (y_lo),
        .weight  (weight_reg),
        .s1_free (s1_free),
        .res     (res)
    );

endmodule
